// ===== sv/ghlp_pkg.sv =====
package ghlp_pkg;

  localparam int TableEntries = 16;
  localparam int MaxHistory   = 16;

  localparam int HistLenW = 5;
  localparam int StatesW  = 9;
  localparam int CtrW     = 8;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  // register index codes, taken from paddr[2]
  localparam logic [0:0] RegHistoryBits   = 1'd0;
  localparam logic [0:0] RegCounterStates = 1'd1;

  localparam logic [HistLenW-1:0] HistBitsReset = 5'd8;
  localparam logic [StatesW-1:0]  StatesReset   = 9'd4;

  typedef struct packed {
    logic [HistLenW-1:0] history_bits;
    logic [StatesW-1:0]  counter_states;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic [MaxHistory-1:0] key;
    logic [CtrW-1:0]       ctr;
  } entry_t;

  // lookup result handed up the row from the least recent end
  typedef struct packed {
    logic            hit;
    logic [CtrW-1:0] ctr;
  } sel_t;

endpackage

// ===== sv/ghlp_cfg.sv =====
module ghlp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ghlp_pkg::AddrW-1:0]   paddr,
  input  logic [ghlp_pkg::DataW-1:0]   pwdata,
  output logic [ghlp_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output ghlp_pkg::cfg_t               cfg_o
);
  import ghlp_pkg::*;

  logic [HistLenW-1:0] hist_bits_q, hist_bits_d;
  logic [StatesW-1:0]  states_q, states_d;
  logic                wr_en;
  logic [0:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2:2];

  always_comb begin
    hist_bits_d = hist_bits_q;
    states_d    = states_q;
    prdata      = '0;
    unique case (reg_idx)
      RegHistoryBits: begin
        prdata = {{(DataW-HistLenW){1'b0}}, hist_bits_q};
        if (wr_en) hist_bits_d = pwdata[HistLenW-1:0];
      end
      RegCounterStates: begin
        prdata = {{(DataW-StatesW){1'b0}}, states_q};
        if (wr_en) states_d = pwdata[StatesW-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_bits_q <= HistBitsReset;
      states_q    <= StatesReset;
    end else begin
      hist_bits_q <= hist_bits_d;
      states_q    <= states_d;
    end
  end

  assign cfg_o.history_bits   = hist_bits_q;
  assign cfg_o.counter_states = states_q;

endmodule

// ===== sv/ghlp_cell.sv =====
module ghlp_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            miss_i,
  input  logic [ghlp_pkg::MaxHistory-1:0] key_i,
  input  ghlp_pkg::entry_t                entry_i,
  input  ghlp_pkg::sel_t                  sel_i,
  output ghlp_pkg::sel_t                  sel_o,
  output ghlp_pkg::entry_t                entry_o
);
  import ghlp_pkg::*;

  logic                  valid_q, valid_d;
  logic [MaxHistory-1:0] key_q, key_d;
  logic [CtrW-1:0]       ctr_q, ctr_d;
  logic                  hit;
  logic                  shift;

  assign hit = valid_q && (key_q == key_i);

  always_comb begin
    if (hit) begin
      sel_o.hit = 1'b1;
      sel_o.ctr = ctr_q;
    end else begin
      sel_o = sel_i;
    end
  end

  // take the neighbor's entry when the hit lies here or further down, or on a miss
  assign shift = step_i && (miss_i || sel_o.hit);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    ctr_d   = ctr_q;
    if (shift) begin
      valid_d = entry_i.valid;
      key_d   = entry_i.key;
      ctr_d   = entry_i.ctr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    ctr_q <= ctr_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.ctr   = ctr_q;

endmodule

// ===== sv/global_history_lru_predictor_top.sv =====
// Global history predictor with a fully associative, LRU-ordered pattern table.
// Input channel (in_valid_i / in_ready_o / taken_i): one transaction per
// resolved branch, carrying its actual outcome.
// Output channel (out_valid_o / out_ready_i / predict_taken_o): one transaction
// per input, the prediction made from the table before it was updated.
// The table is a row of cells kept in recency order, most recent first. Each
// lookup compares the history key against every cell at once; the hit entry,
// or a fresh one on a miss, is written to the head while the cells above the
// hit move one place down, dropping the least recent entry when full.
// The prediction is registered in the output register; throughput is one
// branch per cycle while the receiver takes each prediction as it comes.
// When the receiver stalls, the prediction waits in the output register and
// further branches are refused until it is taken.
// Reset empties the table, clears history and the output valid flag, and loads
// history_bits = 8 and counter_states = 4. Registers sit on the APB port at
// byte addresses 0 and 4; write them only while no transaction is pending.
module global_history_lru_predictor_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ghlp_pkg::AddrW-1:0]   paddr,
  input  logic [ghlp_pkg::DataW-1:0]   pwdata,
  output logic [ghlp_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         taken_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         predict_taken_o
);
  import ghlp_pkg::*;

  cfg_t                  cfg;
  logic [HistLenW-1:0]   hist_len;
  logic [StatesW-1:0]    states;
  logic [CtrW-1:0]       half;
  logic [StatesW-1:0]    ctr_top;
  logic [MaxHistory:0]   hist_mask;
  logic [MaxHistory-1:0] hist_q, hist_d;
  logic                  out_valid_q, out_valid_d;
  logic                  pred_q, pred_d;
  logic                  step;
  logic                  miss;
  logic [CtrW-1:0]       ctr_cur;
  logic [CtrW-1:0]       ctr_new;
  entry_t                head;
  entry_t                ent [TableEntries];
  sel_t                  sel [TableEntries+1];

  ghlp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    hist_len = cfg.history_bits;
    if (hist_len == '0) hist_len = HistLenW'(1);
    else if (32'(hist_len) > MaxHistory) hist_len = HistLenW'(MaxHistory);
    states = cfg.counter_states;
    if (states < StatesW'(2)) states = StatesW'(2);
    else if (states > StatesW'(256)) states = StatesW'(256);
  end

  assign half    = states[StatesW-1:1];
  assign ctr_top = states - StatesW'(1);

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  assign sel[TableEntries] = '0;
  assign miss = !sel[0].hit;

  for (genvar i = 0; i < TableEntries; i++) begin : g_row
    if (i == 0) begin : g_head
      ghlp_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .step_i  (step),
        .miss_i  (miss),
        .key_i   (hist_q),
        .entry_i (head),
        .sel_i   (sel[i+1]),
        .sel_o   (sel[i]),
        .entry_o (ent[i])
      );
    end else begin : g_body
      ghlp_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .step_i  (step),
        .miss_i  (miss),
        .key_i   (hist_q),
        .entry_i (ent[i-1]),
        .sel_i   (sel[i+1]),
        .sel_o   (sel[i]),
        .entry_o (ent[i])
      );
    end
  end

  // a fresh entry starts at half plus the newest history bit
  assign ctr_cur = sel[0].hit ? sel[0].ctr : (half + CtrW'(hist_q[0]));

  always_comb begin
    ctr_new = ctr_cur;
    if (taken_i) begin
      if ({1'b0, ctr_cur} < ctr_top) ctr_new = ctr_cur + CtrW'(1);
    end else begin
      if (ctr_cur != '0) ctr_new = ctr_cur - CtrW'(1);
    end
  end

  assign head.valid = 1'b1;
  assign head.key   = hist_q;
  assign head.ctr   = ctr_new;

  assign hist_mask = ({{MaxHistory{1'b0}}, 1'b1} << hist_len) - {{MaxHistory{1'b0}}, 1'b1};

  always_comb begin
    hist_d      = hist_q;
    pred_d      = pred_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (step) begin
      hist_d      = ({hist_q[MaxHistory-2:0], 1'b0} & hist_mask[MaxHistory-1:0])
                    | {{(MaxHistory-1){1'b0}}, taken_i};
      pred_d      = ctr_cur > half;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hist_q      <= hist_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pred_q <= pred_d;
  end

  assign out_valid_o     = out_valid_q;
  assign predict_taken_o = pred_q;

endmodule
